[hw/rtl/wrlm_pkg.sv]
package wrlm_pkg;

  localparam int MAX_RULES_DEF    = 8;
  localparam int MAX_RULE_LEN_DEF = 32;

  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 3;
  localparam int RESULT_INDEX_W = 3;

  localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [CHAR_W-1:0] DENY_BYTE = 8'h2D;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR     = 3'd0,
    KIND_RULE_BYTE = 3'd1,
    KIND_RULE_END  = 3'd2,
    KIND_NAME_BYTE = 3'd3,
    KIND_NAME_END  = 3'd4
  } kind_t;

endpackage

[hw/rtl/wildcard_rule_list_matcher_core.sv]
// Ordered wildcard rule list matcher. Rules are loaded one byte per transaction; a leading '-'
// makes a rule a deny rule, '*' matches any run of bytes (also an empty one) and every other
// byte matches itself. Name bytes then stream in and each one advances a match column for every
// loaded rule. The end-of-name transaction produces one result: the verdict of the
// lowest-numbered matching rule, its index, and a sticky flag telling that a rule was too
// long or that too many rules were loaded. Every transaction passes through an input register
// and one pass of logic into the state and result registers, so one transaction is taken per
// clock cycle; the only back pressure is a held result while another end of name is waiting.
// The result is registered when its end-of-name transaction leaves the input register.
module wildcard_rule_list_matcher_core #(
  parameter int MAX_RULES    = wrlm_pkg::MAX_RULES_DEF,
  parameter int MAX_RULE_LEN = wrlm_pkg::MAX_RULE_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wrlm_pkg::KIND_W-1:0]         in_kind,
  input  logic [wrlm_pkg::CHAR_W-1:0]         in_char_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_allowed,
  output logic                                out_matched,
  output logic [wrlm_pkg::RESULT_INDEX_W-1:0] out_rule_index,
  output logic                                out_rules_truncated
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int POS_W = $clog2(MAX_RULE_LEN + 1);
  localparam int COL_W = MAX_RULE_LEN + 1;

  logic                          s1_valid_r;
  logic [wrlm_pkg::KIND_W-1:0]   s1_kind_r;
  logic [wrlm_pkg::CHAR_W-1:0]   s1_char_r;
  logic                          s1_adv;
  logic                          s1_fire;

  logic [wrlm_pkg::CHAR_W-1:0]   text_r [MAX_RULES][MAX_RULE_LEN];
  logic                          star_r [MAX_RULES][MAX_RULE_LEN];
  logic [POS_W-1:0]              len_r  [MAX_RULES];
  logic                          deny_r [MAX_RULES];
  logic                          bad_r  [MAX_RULES];
  logic [COL_W-1:0]              col_r  [MAX_RULES];
  logic [CNT_W-1:0]              count_r;
  logic [POS_W-1:0]              pos_r;
  logic                          overflow_r;

  logic [COL_W-1:0]              col_adv [MAX_RULES];
  logic [MAX_RULES-1:0]          hit;
  logic                          found;
  logic                          allow;
  logic [wrlm_pkg::RESULT_INDEX_W-1:0] idx;

  logic                          out_valid_r;
  logic                          out_allowed_r;
  logic                          out_matched_r;
  logic [wrlm_pkg::RESULT_INDEX_W-1:0] out_rule_index_r;
  logic                          out_rules_truncated_r;

  logic                          full;
  logic                          slot_deny;

  assign s1_adv   = (s1_kind_r != wrlm_pkg::KIND_NAME_END) || !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r <= in_kind;
      s1_char_r <= in_char_value;
    end
  end

  assign full = (count_r >= CNT_W'(MAX_RULES));

  always_comb begin
    slot_deny = 1'b0;
    for (int r = 0; r < MAX_RULES; r++) begin
      if (count_r == CNT_W'(r)) begin
        slot_deny = deny_r[r];
      end
    end
  end

  // Star closure followed by one byte step, per rule.
  always_comb begin
    logic [COL_W-1:0] clo;
    logic [COL_W-1:0] nxt;
    logic             active;
    for (int r = 0; r < MAX_RULES; r++) begin
      clo = col_r[r];
      for (int i = 0; i < MAX_RULE_LEN; i++) begin
        if ((POS_W'(i) < len_r[r]) && star_r[r][i] && clo[i]) begin
          clo[i+1] = 1'b1;
        end
      end
      nxt = '0;
      for (int i = 0; i < MAX_RULE_LEN; i++) begin
        if (POS_W'(i) < len_r[r]) begin
          if (star_r[r][i]) begin
            nxt[i+1] = clo[i] | nxt[i] | clo[i+1];
          end else begin
            nxt[i+1] = (text_r[r][i] == s1_char_r) && clo[i];
          end
        end
      end
      col_adv[r] = nxt;
      active = (CNT_W'(r) < count_r) && (len_r[r] != '0) && !bad_r[r];
      hit[r] = 1'b0;
      for (int j = 0; j < COL_W; j++) begin
        if (len_r[r] == POS_W'(j)) begin
          hit[r] = active && clo[j];
        end
      end
    end
  end

  always_comb begin
    found = 1'b0;
    allow = 1'b0;
    idx   = '0;
    for (int r = 0; r < MAX_RULES; r++) begin
      if (hit[r] && !found) begin
        found = 1'b1;
        allow = !deny_r[r];
        idx   = wrlm_pkg::RESULT_INDEX_W'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pos_r      <= '0;
      overflow_r <= 1'b0;
      for (int r = 0; r < MAX_RULES; r++) begin
        len_r[r]  <= '0;
        deny_r[r] <= 1'b0;
        bad_r[r]  <= 1'b0;
        col_r[r]  <= COL_W'(1);
      end
    end else if (s1_fire) begin
      case (s1_kind_r)
        wrlm_pkg::KIND_CLEAR: begin
          count_r    <= '0;
          pos_r      <= '0;
          overflow_r <= 1'b0;
          for (int r = 0; r < MAX_RULES; r++) begin
            len_r[r]  <= '0;
            deny_r[r] <= 1'b0;
            bad_r[r]  <= 1'b0;
            col_r[r]  <= COL_W'(1);
          end
        end
        wrlm_pkg::KIND_RULE_BYTE: begin
          if (full) begin
            overflow_r <= 1'b1;
          end else if (pos_r == '0 && !slot_deny && s1_char_r == wrlm_pkg::DENY_BYTE) begin
            for (int r = 0; r < MAX_RULES; r++) begin
              if (count_r == CNT_W'(r)) begin
                deny_r[r] <= 1'b1;
              end
            end
          end else if (pos_r >= POS_W'(MAX_RULE_LEN)) begin
            overflow_r <= 1'b1;
            for (int r = 0; r < MAX_RULES; r++) begin
              if (count_r == CNT_W'(r)) begin
                bad_r[r] <= 1'b1;
              end
            end
          end else begin
            pos_r <= pos_r + POS_W'(1);
          end
        end
        wrlm_pkg::KIND_RULE_END: begin
          if (full) begin
            overflow_r <= 1'b1;
          end else begin
            for (int r = 0; r < MAX_RULES; r++) begin
              if (count_r == CNT_W'(r)) begin
                len_r[r] <= pos_r;
                col_r[r] <= COL_W'(1);
              end
            end
            count_r <= count_r + CNT_W'(1);
            pos_r   <= '0;
          end
        end
        wrlm_pkg::KIND_NAME_BYTE: begin
          for (int r = 0; r < MAX_RULES; r++) begin
            if (CNT_W'(r) < count_r) begin
              col_r[r] <= col_adv[r];
            end
          end
        end
        wrlm_pkg::KIND_NAME_END: begin
          for (int r = 0; r < MAX_RULES; r++) begin
            col_r[r] <= COL_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Rule text holds no reset; only bytes below a rule's stored length are consulted.
  always_ff @(posedge clk) begin
    if (s1_fire && s1_kind_r == wrlm_pkg::KIND_RULE_BYTE && !full &&
        !(pos_r == '0 && !slot_deny && s1_char_r == wrlm_pkg::DENY_BYTE) &&
        pos_r < POS_W'(MAX_RULE_LEN)) begin
      for (int r = 0; r < MAX_RULES; r++) begin
        for (int i = 0; i < MAX_RULE_LEN; i++) begin
          if (count_r == CNT_W'(r) && pos_r == POS_W'(i)) begin
            text_r[r][i] <= s1_char_r;
            star_r[r][i] <= (s1_char_r == wrlm_pkg::STAR_BYTE);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_kind_r == wrlm_pkg::KIND_NAME_END) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_kind_r == wrlm_pkg::KIND_NAME_END) begin
      out_allowed_r         <= allow;
      out_matched_r         <= found;
      out_rule_index_r      <= idx;
      out_rules_truncated_r <= overflow_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_allowed         = out_allowed_r;
  assign out_matched         = out_matched_r;
  assign out_rule_index      = out_rule_index_r;
  assign out_rules_truncated = out_rules_truncated_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RULES))
    else $error("Rule count beyond the rule limit.");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_RULE_LEN))
    else $error("Load position beyond the rule length limit.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_kind_r == wrlm_pkg::KIND_NAME_END))
    else $error("Input stalled without a held result and a waiting end of name.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_kind_r == wrlm_pkg::KIND_NAME_END) |=> out_valid_r)
    else $error("End of name did not produce a result.");

  a_no_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_matched_r) |-> (out_rule_index_r == '0 && !out_allowed_r))
    else $error("Result without a match carries a rule index or an allow.");

endmodule
